FILE: design/register_file_execute_unit_defines.svh
// Assertion macros used by the file that carries checks.
`ifndef REGISTER_FILE_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_FILE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RFEU_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("register file execute unit check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RFEU_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("register file execute unit check failed");

`endif

FILE: design/rfeu_pkg.sv
`timescale 1ns / 1ps
package rfeu_pkg;

    localparam int DATA_W = 64;
    localparam int IN_W   = 40;
    localparam int OUT_W  = 144;
    localparam int QDEPTH = 2;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_INC  = 5'd2,
        OP_DEC  = 5'd3,
        OP_NEG  = 5'd4,
        OP_MUL  = 5'd5,
        OP_DIV  = 5'd6,
        OP_AND  = 5'd7,
        OP_OR   = 5'd8,
        OP_NAND = 5'd9,
        OP_NOR  = 5'd10,
        OP_XOR  = 5'd11,
        OP_XNOR = 5'd12,
        OP_NOT  = 5'd13,
        OP_SHL  = 5'd14,
        OP_SHR  = 5'd15,
        OP_ROL  = 5'd16,
        OP_ROR  = 5'd17,
        OP_MOVE = 5'd18,
        OP_SWAP = 5'd19
    } op_t;

    typedef enum logic [1:0] {
        CL_ALU,
        CL_MUL,
        CL_DIV,
        CL_NONE
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_WB1,
        ST_WB2,
        ST_DONE
    } bst_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [3:0] dst_a;
        logic [3:0] dst_b;
        logic [1:0] lane_size;
        logic       per_lane;
        logic [2:0] pos_a;
        logic [2:0] pos_b;
        logic [7:0] shift_amount;
        logic       want_first;
        logic       want_second;
        cls_t       cls;
    } instr_t;

    typedef struct packed {
        logic       full;
        logic [1:0] count;
    } fstat_t;

    // Sort an opcode into the unit that carries it out
    function automatic cls_t classify(input op_t op);
        cls_t c;
        unique case (op) inside
            OP_MUL: c = CL_MUL;
            OP_DIV: c = CL_DIV;
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_NEG, OP_AND, OP_OR, OP_NAND,
            OP_NOR, OP_XOR, OP_XNOR, OP_NOT, OP_SHL, OP_SHR, OP_ROL, OP_ROR,
            OP_MOVE, OP_SWAP: c = CL_ALU;
            default: c = CL_NONE;
        endcase
        return c;
    endfunction

    // Magnitude of a two's complement word
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

FILE: design/register_file_execute_unit.sv
`timescale 1ns / 1ps
// Channel   | Dir | Signals                   | Item
// ----------+-----+---------------------------+-----------------------------------
// s_axis    | in  | s_tvalid s_tready s_tdata | one decoded instruction (40 bits)
// m_axis    | out | m_tvalid m_tready m_tdata | two register write reports
//
// Logic, shift, move, swap and add/sub items pass from acceptance to result
// through queue pop and register read, execute, two write-back states and
// the output register load. Multiply adds its own steps (four 32x32
// partial products, the last accumulate, the sign step and the done flag);
// divide adds one quotient bit a cycle, the sign step and the done flag.
// Reset clears the queue, the state machine and the register valid bits;
// every register then reads as zero until written. The two-entry queue takes
// items while the back end works; a stalled result holds in the output register.
`include "register_file_execute_unit_defines.svh"
module register_file_execute_unit
    import rfeu_pkg::*;
#(
    parameter int REG_COUNT = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // opcode, src_a, src_b, dst_a, dst_b, lane_size, per_lane, pos_a, pos_b,
    // shift_amount, want_first, want_second
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // first_write_valid, first_write_reg, first_write_value, second_write_valid,
    // second_write_reg, second_write_value, zero pad
    output logic [OUT_W-1:0] m_tdata
);

    logic   pop;
    logic   head_valid;
    instr_t head;
    fstat_t fstat;

    rfeu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .stat       (fstat)
    );

    rfeu_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Checks
    `RFEU_ASSERT_IMP(a_q_depth, 1'b1, fstat.count <= 2'(QDEPTH))
    `RFEU_ASSERT_NXT(a_q_fill, s_tvalid && s_tready && !pop && fstat.count == 2'd0, fstat.count == 2'd1)
    `RFEU_ASSERT_IMP(a_first_reg, m_tvalid && m_tdata[0], m_tdata[4:1] < REG_COUNT)
    `RFEU_ASSERT_IMP(a_second_reg, m_tvalid && m_tdata[69], m_tdata[73:70] < REG_COUNT)

endmodule

FILE: design/rfeu_front.sv
`timescale 1ns / 1ps
module rfeu_front
    import rfeu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            pop,
    output logic            head_valid,
    output instr_t          head,
    output fstat_t          stat
);

    instr_t     q_mem [QDEPTH];
    instr_t     din;
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    // Unpack and classify the incoming item
    always_comb
    begin
        din.op           = op_t'(s_tdata[4:0]);
        din.src_a        = s_tdata[8:5];
        din.src_b        = s_tdata[12:9];
        din.dst_a        = s_tdata[16:13];
        din.dst_b        = s_tdata[20:17];
        din.lane_size    = s_tdata[22:21];
        din.per_lane     = s_tdata[23];
        din.pos_a        = s_tdata[26:24];
        din.pos_b        = s_tdata[29:27];
        din.shift_amount = s_tdata[37:30];
        din.want_first   = s_tdata[38];
        din.want_second  = s_tdata[39];
        din.cls          = classify(op_t'(s_tdata[4:0]));
    end

    assign stat.full  = (cnt_reg == 2'(QDEPTH));
    assign stat.count = cnt_reg;
    assign s_tready   = !stat.full;
    assign push       = s_tvalid && s_tready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_mem[rp_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the item in the queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= din;
        end
    end

endmodule

FILE: design/rfeu_mul.sv
`timescale 1ns / 1ps
module rfeu_mul
    import rfeu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic              neg,
    output logic              done,
    output logic [DATA_W-1:0] hi,
    output logic [DATA_W-1:0] lo
);

    logic [DATA_W-1:0]   a_reg, b_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   prod_reg, prod_next;
    logic [2*DATA_W-1:0] acc_reg, res_reg, addend;
    logic [2:0]          cnt_reg;
    logic                busy_reg, done_reg;
    logic [31:0]         ma, mb;
    logic [6:0]          sh;

    // Select one 32x32 partial product per step
    always_comb
    begin
        ma        = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        mb        = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        prod_next = {32'd0, ma} * {32'd0, mb};
    end

    // Weight of the partial product taken in the step before
    always_comb
    begin
        case (cnt_reg)
            3'd1:    sh = 7'd0;
            3'd4:    sh = 7'd64;
            default: sh = 7'd32;
        endcase
        addend = {64'd0, prod_reg} << sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'd5);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Accumulate partial products, then apply the sign
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            neg_reg <= neg;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                prod_reg <= prod_next;
            end
            if (cnt_reg != 3'd0 && cnt_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + addend;
            end
            if (cnt_reg == 3'd5)
            begin
                res_reg <= neg_reg ? (~acc_reg + 1'b1) : acc_reg;
            end
        end
    end

    assign done = done_reg;
    assign hi   = res_reg[2*DATA_W-1:DATA_W];
    assign lo   = res_reg[DATA_W-1:0];

endmodule

FILE: design/rfeu_div.sv
`timescale 1ns / 1ps
module rfeu_div
    import rfeu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] n,
    input  logic [DATA_W-1:0] d,
    input  logic              neg,
    output logic              done,
    output logic [DATA_W-1:0] q,
    output logic [DATA_W-1:0] r
);

    logic [DATA_W-1:0] rem_reg, quo_reg, d_reg, q_reg, r_reg;
    logic              neg_reg;
    logic [6:0]        cnt_reg;
    logic              busy_reg, done_reg;
    logic [DATA_W:0]   sh, diff;
    logic              ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        sh   = {rem_reg, quo_reg[DATA_W-1]};
        diff = sh - {1'b0, d_reg};
        ge   = (sh >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 7'(DATA_W));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DATA_W))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= n;
            d_reg   <= d;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 7'(DATA_W))
            begin
                rem_reg <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], ge};
            end
            else
            begin
                q_reg <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                r_reg <= neg_reg ? (~rem_reg + 1'b1) : rem_reg;
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign r    = r_reg;

endmodule

FILE: design/rfeu_back.sv
`timescale 1ns / 1ps
module rfeu_back
    import rfeu_pkg::*;
#(
    parameter int REG_COUNT = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  instr_t           head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int         AW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [4:0] RC_W = 5'(REG_COUNT);

    bst_t              state_reg, state_next;
    instr_t            ir_reg;
    logic [DATA_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0] rda_reg, rdb_reg;
    logic              hita_reg, hitb_reg;
    logic [3:0]        ra, rb;
    logic [DATA_W-1:0] opa, opb;

    logic              fv_reg, sv_reg;
    logic [3:0]        fr_reg, sr_reg;
    logic [DATA_W-1:0] fval_reg, sval_reg;

    logic              wr_en;
    logic [3:0]        wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              out_free, out_load;
    logic              mul_start, div_start, mul_done, div_done;
    logic [DATA_W-1:0] mul_hi, mul_lo, div_q, div_r;
    logic              sgn;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [DATA_W-1:0] alu_val, swap_b;
    logic [3:0]        tgt_a;

    function automatic logic reg_ok(input logic [3:0] idx);
        return ({1'b0, idx} < RC_W);
    endfunction

    // Register file reads for the item at the head of the queue
    assign ra = head.src_a;
    assign rb = (head.op == OP_MOVE) ? head.dst_a : head.src_b;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (pop)
        begin
            rda_reg <= mem[ra[AW-1:0]];
            rdb_reg <= mem[rb[AW-1:0]];
        end
    end

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            hita_reg <= 1'b0;
            hitb_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (pop)
            begin
                hita_reg <= reg_ok(ra) && vld_reg[ra[AW-1:0]];
                hitb_reg <= reg_ok(rb) && vld_reg[rb[AW-1:0]];
            end
        end
    end

    assign opa = hita_reg ? rda_reg : '0;
    assign opb = hitb_reg ? rdb_reg : '0;

    // Combinational operations
    always_comb
    begin
        logic [1:0]        le;
        logic [2:0]        lbm, pm;
        logic [DATA_W-1:0] p, qv, sum, lm, r1, v1, v2;
        logic              cin, c;
        logic [8:0]        s9;
        logic [5:0]        ss, ds, c6;

        le = ir_reg.per_lane ? ir_reg.lane_size : 2'd3;
        case (le)
            2'd0:    lbm = 3'd0;
            2'd1:    lbm = 3'd1;
            2'd2:    lbm = 3'd3;
            default: lbm = 3'd7;
        endcase

        // Operands for the carry chain
        case (ir_reg.op)
            OP_SUB:  begin p = opa; qv = ~opb;  cin = 1'b1; end
            OP_INC:  begin p = opa; qv = '0;    cin = 1'b1; end
            OP_DEC:  begin p = opa; qv = '1;    cin = 1'b0; end
            OP_NEG:  begin p = '0;  qv = ~opa;  cin = 1'b1; end
            default: begin p = opa; qv = opb;   cin = 1'b0; end
        endcase

        // Byte-wise carry chain, cut at lane edges
        c   = cin;
        sum = '0;
        for (int k = 0; k < 8; k++)
        begin
            if ((3'(k) & lbm) == 3'd0)
            begin
                c = cin;
            end
            s9 = {1'b0, p[k*8 +: 8]} + {1'b0, qv[k*8 +: 8]} + {8'd0, c};
            sum[k*8 +: 8] = s9[7:0];
            c = s9[8];
        end

        // Lane mask and positions for move and swap
        case (ir_reg.lane_size)
            2'd0:    begin lm = 64'hFF;        pm = 3'd7; end
            2'd1:    begin lm = 64'hFFFF;      pm = 3'd3; end
            2'd2:    begin lm = 64'hFFFF_FFFF; pm = 3'd1; end
            default: begin lm = '1;            pm = 3'd0; end
        endcase
        ss = 6'({3'b0, ir_reg.pos_a & pm} << ({1'b0, ir_reg.lane_size} + 3'd3));
        ds = 6'({3'b0, ir_reg.pos_b & pm} << ({1'b0, ir_reg.lane_size} + 3'd3));
        v1 = (opa >> ss) & lm;
        v2 = (opb >> ds) & lm;
        r1 = opa & ~(lm << ss);
        if (ir_reg.src_a == ir_reg.src_b)
        begin
            r1     = (r1 & ~(lm << ds)) | (v2 << ss) | (v1 << ds);
            swap_b = r1;
        end
        else
        begin
            swap_b = (opb & ~(lm << ds)) | (v1 << ds);
            r1     = r1 | (v2 << ss);
        end

        c6 = ir_reg.shift_amount[5:0];
        case (ir_reg.op) inside
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_NEG: alu_val = sum;
            OP_AND:  alu_val = opa & opb;
            OP_OR:   alu_val = opa | opb;
            OP_NAND: alu_val = ~(opa & opb);
            OP_NOR:  alu_val = ~(opa | opb);
            OP_XOR:  alu_val = opa ^ opb;
            OP_XNOR: alu_val = ~(opa ^ opb);
            OP_NOT:  alu_val = ~opa;
            OP_SHL:  alu_val = (ir_reg.shift_amount[7:6] != 2'd0) ? '0 : (opa << c6);
            OP_SHR:  alu_val = (ir_reg.shift_amount[7:6] != 2'd0) ? '0 : (opa >> c6);
            OP_ROL:  alu_val = (opa << c6) | (opa >> (7'd64 - {1'b0, c6}));
            OP_ROR:  alu_val = (opa >> c6) | (opa << (7'd64 - {1'b0, c6}));
            OP_MOVE: alu_val = (opb & ~(lm << ds)) | (v1 << ds);
            OP_SWAP: alu_val = r1;
            default: alu_val = '0;
        endcase
    end

    assign tgt_a = (ir_reg.op == OP_SWAP) ? ir_reg.src_a : ir_reg.dst_a;
    assign sgn   = opa[DATA_W-1] ^ opb[DATA_W-1];

    rfeu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mag(opa)),
        .b     (mag(opb)),
        .neg   (sgn),
        .done  (mul_done),
        .hi    (mul_hi),
        .lo    (mul_lo)
    );

    rfeu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (mag(opa)),
        .d     (mag((opb == '0) ? DATA_W'(1) : opb)),
        .neg   (sgn),
        .done  (div_done),
        .q     (div_q),
        .r     (div_r)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (head_valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (ir_reg.cls == CL_MUL)
                    state_next = ST_MUL;
                else if (ir_reg.cls == CL_DIV)
                    state_next = ST_DIV;
                else
                    state_next = ST_WB1;
            end
            ST_MUL:  if (mul_done) state_next = ST_WB1;
            ST_DIV:  if (div_done) state_next = ST_WB1;
            ST_WB1:  state_next = ST_WB2;
            ST_WB2:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        pop       = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = fr_reg;
        wr_data   = fval_reg;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop = head_valid;
            ST_EXEC:
            begin
                mul_start = (ir_reg.cls == CL_MUL);
                div_start = (ir_reg.cls == CL_DIV);
            end
            ST_WB1:  wr_en = fv_reg;
            ST_WB2:
            begin
                wr_en   = sv_reg;
                wr_addr = sr_reg;
                wr_data = sval_reg;
            end
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Latch the instruction and collect its writes
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ir_reg <= head;
        end
        if (state_reg == ST_EXEC)
        begin
            fv_reg   <= (ir_reg.cls == CL_ALU) && reg_ok(tgt_a);
            fr_reg   <= ((ir_reg.cls == CL_ALU) && reg_ok(tgt_a)) ? tgt_a : 4'd0;
            fval_reg <= ((ir_reg.cls == CL_ALU) && reg_ok(tgt_a)) ? alu_val : '0;
            sv_reg   <= (ir_reg.op == OP_SWAP) && reg_ok(ir_reg.src_b);
            sr_reg   <= ((ir_reg.op == OP_SWAP) && reg_ok(ir_reg.src_b)) ? ir_reg.src_b : 4'd0;
            sval_reg <= ((ir_reg.op == OP_SWAP) && reg_ok(ir_reg.src_b)) ? swap_b : '0;
        end
        else if ((state_reg == ST_MUL && mul_done) || (state_reg == ST_DIV && div_done))
        begin
            fv_reg <= ir_reg.want_first && reg_ok(ir_reg.dst_a);
            fr_reg <= (ir_reg.want_first && reg_ok(ir_reg.dst_a)) ? ir_reg.dst_a : 4'd0;
            sv_reg <= ir_reg.want_second && reg_ok(ir_reg.dst_b);
            sr_reg <= (ir_reg.want_second && reg_ok(ir_reg.dst_b)) ? ir_reg.dst_b : 4'd0;
            if (ir_reg.want_first && reg_ok(ir_reg.dst_a))
                fval_reg <= (state_reg == ST_MUL) ? mul_hi : div_q;
            else
                fval_reg <= '0;
            if (ir_reg.want_second && reg_ok(ir_reg.dst_b))
                sval_reg <= (state_reg == ST_MUL) ? mul_lo : div_r;
            else
                sval_reg <= '0;
        end
        if (out_load)
        begin
            m_tdata_reg <= {6'd0, sval_reg, sr_reg, sv_reg, fval_reg, fr_reg, fv_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
